### src/lru_key_table_top_defines.svh
// ----------------------------------------------------------------------------
// lru_key_table_top_defines: assertion macros for the LRU key table
// Concurrent assertion helpers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TABLE_TOP_DEFINES_SVH
`define LRU_KEY_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define LKT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/lkt_pkg.sv
// ----------------------------------------------------------------------------
// lkt_pkg: shared types and constants of the LRU key table
// Command, status, sequencer and rank update encodings; port field layout.
// ----------------------------------------------------------------------------
package lkt_pkg;

  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int KEY_IO_W   = 32;
  localparam int FRAME_IO_W = 32;
  localparam int FLAGS_W    = 8;
  localparam int TDATA_W    = KEY_IO_W + FRAME_IO_W + FLAGS_W;
  localparam int FRAME_LSB  = KEY_IO_W;
  localparam int FLAGS_LSB  = KEY_IO_W + FRAME_IO_W;
  localparam int IDX_MAX_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND      = 3'd0,
    CMD_PUSH      = 3'd1,
    CMD_POP_LRU   = 3'd2,
    CMD_POP_KEY   = 3'd3,
    CMD_POP_FRAME = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT  = 2'd0,
    STAT_MISS = 2'd1,
    STAT_NEW  = 2'd2,
    STAT_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    RANK_NONE,
    RANK_FRONT,
    RANK_INSERT,
    RANK_REMOVE
  } rank_op_e;

  typedef struct packed {
    rank_op_e               op;
    logic [IDX_MAX_W-1:0]   slot;
    logic [IDX_MAX_W-1:0]   rank;
  } rank_upd_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_stat_t;

endpackage

### src/lkt_ram.sv
// ----------------------------------------------------------------------------
// lkt_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/lkt_rank.sv
// ----------------------------------------------------------------------------
// lkt_rank: valid bits and recency ranks of the LRU key table
// Applies one rank update to all slots in parallel; reads one slot for scan.
// ----------------------------------------------------------------------------
module lkt_rank #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lkt_pkg::rank_upd_t         upd_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_idx_i,
  output logic                       rd_valid_o,
  output logic [$clog2(ENTRIES)-1:0] rd_rank_o
);

  localparam int IW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [IW-1:0]      rank_d [ENTRIES];
  logic [IW-1:0]      slot;
  logic [IW-1:0]      ref_rank;

  assign slot     = upd_i.slot[IW-1:0];
  assign ref_rank = upd_i.rank[IW-1:0];

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    for (int i = 0; i < ENTRIES; i++) begin
      case (upd_i.op)
        lkt_pkg::RANK_FRONT: begin
          if (IW'(i) == slot) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && rank_q[i] < ref_rank) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        lkt_pkg::RANK_INSERT: begin
          if (IW'(i) == slot) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IW'(1);
          end
        end
        lkt_pkg::RANK_REMOVE: begin
          if (IW'(i) == slot) begin
            valid_d[i] = 1'b0;
            rank_d[i]  = '0;
          end else if (valid_q[i] && rank_q[i] > ref_rank) begin
            rank_d[i] = rank_q[i] - IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rank_q  <= '{default: '0};
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];

endmodule

### src/lkt_scan.sv
// ----------------------------------------------------------------------------
// lkt_scan: shared compare unit of the LRU key table
// Checks one slot per cycle while proc_i is high against the request and keeps the best match
// and the lowest free slot.
// ----------------------------------------------------------------------------
module lkt_scan #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int FRAME_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         proc_i,
  input  logic [$clog2(ENTRIES)-1:0]   idx_i,
  input  lkt_pkg::cmd_e                cmd_i,
  input  logic [KEY_WIDTH-1:0]         key_i,
  input  logic [FRAME_WIDTH-1:0]       frame_i,
  input  logic                         ent_valid_i,
  input  logic [$clog2(ENTRIES)-1:0]   ent_rank_i,
  input  logic [KEY_WIDTH-1:0]         ent_key_i,
  input  logic [FRAME_WIDTH-1:0]       ent_frame_i,
  input  logic [lkt_pkg::FLAGS_W-1:0]  ent_flags_i,
  output lkt_pkg::scan_stat_t          stat_o,
  output logic [$clog2(ENTRIES)-1:0]   hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0]   hit_rank_o,
  output logic [KEY_WIDTH-1:0]         hit_key_o,
  output logic [FRAME_WIDTH-1:0]       hit_frame_o,
  output logic [lkt_pkg::FLAGS_W-1:0]  hit_flags_o,
  output logic [$clog2(ENTRIES)-1:0]   free_idx_o
);

  localparam int IW = $clog2(ENTRIES);

  logic                        hit_q, hit_d;
  logic                        free_q, free_d;
  logic [IW-1:0]               hit_idx_q, hit_rank_q, free_idx_q;
  logic [KEY_WIDTH-1:0]        hit_key_q;
  logic [FRAME_WIDTH-1:0]      hit_frame_q;
  logic [lkt_pkg::FLAGS_W-1:0] hit_flags_q;
  logic                        match;
  logic                        better;
  logic                        take_hit;
  logic                        take_free;

  always_comb begin
    match  = 1'b0;
    better = ent_rank_i < hit_rank_q;
    case (cmd_i)
      lkt_pkg::CMD_FIND, lkt_pkg::CMD_PUSH, lkt_pkg::CMD_POP_KEY: begin
        match = ent_valid_i && (ent_key_i == key_i);
      end
      lkt_pkg::CMD_POP_FRAME: begin
        match = ent_valid_i && (ent_frame_i == frame_i);
      end
      lkt_pkg::CMD_POP_LRU: begin
        match  = ent_valid_i;
        better = ent_rank_i > hit_rank_q;
      end
      default: begin
        match = 1'b0;
      end
    endcase
    take_hit  = proc_i && match && (!hit_q || better);
    take_free = proc_i && !ent_valid_i && !free_q;
    hit_d     = start_i ? 1'b0 : (hit_q || take_hit);
    free_d    = start_i ? 1'b0 : (free_q || take_free);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_hit) begin
      hit_idx_q   <= idx_i;
      hit_rank_q  <= ent_rank_i;
      hit_key_q   <= ent_key_i;
      hit_frame_q <= ent_frame_i;
      hit_flags_q <= ent_flags_i;
    end
    if (take_free) begin
      free_idx_q <= idx_i;
    end
  end

  assign stat_o.hit  = hit_q;
  assign stat_o.free = free_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rank_o  = hit_rank_q;
  assign hit_key_o   = hit_key_q;
  assign hit_frame_o = hit_frame_q;
  assign hit_flags_o = hit_flags_q;
  assign free_idx_o  = free_idx_q;

endmodule

### src/lru_key_table_top.sv
// ----------------------------------------------------------------------------
// lru_key_table_top: LRU key table
// Keeps up to ENTRIES entries (key, frame, flags) in recency order and runs
// find, push and pop requests against them.
//
//   channel  dir  tuser           tdata (low bit up)
//   s_axis   in   cmd[2:0]        key_in[31:0] frame_in[63:32] flags_in[71:64]
//   m_axis   out  status[1:0]     key_out[31:0] frame_out[63:32] flags_out[71:64]
//
// After acceptance a request reads every entry of the entry RAM in turn
// through the one shared compare unit, then applies one update of ranks
// and valid bits; the next ready follows that update.
// Reset clears all valid bits and ranks at once; no clearing pass.
// A result not taken holds in the output register; the next request is
// accepted meanwhile, and its update cycle waits until the register frees.
// ----------------------------------------------------------------------------
module lru_key_table_top #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int FRAME_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // key_in, frame_in, flags_in
  input  logic [lkt_pkg::TDATA_W-1:0]   s_axis_tdata,
  // cmd
  input  logic [lkt_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // key_out, frame_out, flags_out
  output logic [lkt_pkg::TDATA_W-1:0]   m_axis_tdata,
  // status
  output logic [lkt_pkg::STATUS_W-1:0]  m_axis_tuser
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int MEM_W = KEY_WIDTH + FRAME_WIDTH + lkt_pkg::FLAGS_W;

  lkt_pkg::state_e             state_q, state_d;
  lkt_pkg::cmd_e               cmd_q;
  logic [KEY_WIDTH-1:0]        key_q;
  logic [FRAME_WIDTH-1:0]      frame_q;
  logic [lkt_pkg::FLAGS_W-1:0] flags_q;
  logic [IW:0]                 issue_q, issue_d;
  logic                        pvld_q, pvld_d;
  logic [IW-1:0]               pidx_q;
  logic                        out_vld_q, out_vld_d;
  logic [lkt_pkg::TDATA_W-1:0] out_data_q;
  lkt_pkg::status_e            out_stat_q;

  logic                        accept;
  logic                        ram_re;
  logic                        ram_we;
  logic                        load_out;
  logic [MEM_W-1:0]            ram_rdata;
  logic                        ent_valid;
  logic [IW-1:0]               ent_rank;

  lkt_pkg::scan_stat_t         scan_stat;
  logic [IW-1:0]               hit_idx, hit_rank, free_idx;
  logic [KEY_WIDTH-1:0]        hit_key;
  logic [FRAME_WIDTH-1:0]      hit_frame;
  logic [lkt_pkg::FLAGS_W-1:0] hit_flags;

  lkt_pkg::rank_upd_t          upd, upd_gated;
  logic                        insert;
  lkt_pkg::status_e            res_stat;
  logic [KEY_WIDTH-1:0]        res_key;
  logic [FRAME_WIDTH-1:0]      res_frame;
  logic [lkt_pkg::FLAGS_W-1:0] res_flags;
  logic                        res_zero;
  logic [63:0]                 res_key_ext;
  logic [63:0]                 res_frame_ext;

  assign accept = s_axis_tvalid && s_axis_tready;

  // Sequencer
  always_comb begin
    state_d       = state_q;
    issue_d       = issue_q;
    s_axis_tready = (state_q == lkt_pkg::ST_IDLE);
    ram_re        = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      lkt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lkt_pkg::ST_SCAN;
          issue_d = '0;
        end
      end
      lkt_pkg::ST_SCAN: begin
        if (issue_q < (IW + 1)'(ENTRIES)) begin
          ram_re  = 1'b1;
          issue_d = issue_q + (IW + 1)'(1);
        end
        if (pvld_q && pidx_q == IW'(ENTRIES - 1)) begin
          state_d = lkt_pkg::ST_UPDATE;
        end
      end
      lkt_pkg::ST_UPDATE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = lkt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkt_pkg::ST_IDLE;
      end
    endcase
    pvld_d = ram_re;
  end

  // Outcome of the scan
  always_comb begin
    upd       = '0;
    upd.op    = lkt_pkg::RANK_NONE;
    insert    = 1'b0;
    res_stat  = lkt_pkg::STAT_MISS;
    res_key   = hit_key;
    res_frame = hit_frame;
    res_flags = hit_flags;
    res_zero  = 1'b1;
    case (cmd_q)
      lkt_pkg::CMD_FIND, lkt_pkg::CMD_PUSH: begin
        if (scan_stat.hit) begin
          res_stat = lkt_pkg::STAT_HIT;
          res_zero = 1'b0;
          upd.op   = lkt_pkg::RANK_FRONT;
          upd.slot = lkt_pkg::IDX_MAX_W'(hit_idx);
          upd.rank = lkt_pkg::IDX_MAX_W'(hit_rank);
        end else if (cmd_q == lkt_pkg::CMD_PUSH) begin
          if (scan_stat.free) begin
            res_stat  = lkt_pkg::STAT_NEW;
            res_zero  = 1'b0;
            res_key   = key_q;
            res_frame = frame_q;
            res_flags = flags_q;
            insert    = 1'b1;
            upd.op    = lkt_pkg::RANK_INSERT;
            upd.slot  = lkt_pkg::IDX_MAX_W'(free_idx);
          end else begin
            res_stat = lkt_pkg::STAT_FULL;
          end
        end
      end
      lkt_pkg::CMD_POP_LRU, lkt_pkg::CMD_POP_KEY, lkt_pkg::CMD_POP_FRAME: begin
        if (scan_stat.hit) begin
          res_stat = lkt_pkg::STAT_HIT;
          res_zero = 1'b0;
          upd.op   = lkt_pkg::RANK_REMOVE;
          upd.slot = lkt_pkg::IDX_MAX_W'(hit_idx);
          upd.rank = lkt_pkg::IDX_MAX_W'(hit_rank);
        end
      end
      default: begin
        res_stat = lkt_pkg::STAT_MISS;
      end
    endcase
  end

  always_comb begin
    upd_gated = upd;
    if (!load_out) begin
      upd_gated.op = lkt_pkg::RANK_NONE;
    end
  end

  assign ram_we        = load_out && insert;
  assign res_key_ext   = 64'(res_key);
  assign res_frame_ext = 64'(res_frame);
  assign out_vld_d     = load_out || (out_vld_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lkt_pkg::ST_IDLE;
      issue_q   <= '0;
      pvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      pvld_q    <= pvld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= lkt_pkg::cmd_e'(s_axis_tuser);
      key_q   <= KEY_WIDTH'(s_axis_tdata[lkt_pkg::KEY_IO_W-1:0]);
      frame_q <= FRAME_WIDTH'(s_axis_tdata[lkt_pkg::FRAME_LSB +: lkt_pkg::FRAME_IO_W]);
      flags_q <= s_axis_tdata[lkt_pkg::FLAGS_LSB +: lkt_pkg::FLAGS_W];
    end
    pidx_q <= issue_q[IW-1:0];
    if (load_out) begin
      out_stat_q <= res_stat;
      out_data_q <= res_zero ? '0 :
                    {res_flags, res_frame_ext[lkt_pkg::FRAME_IO_W-1:0],
                     res_key_ext[lkt_pkg::KEY_IO_W-1:0]};
    end
  end

  lkt_ram #(
    .WIDTH (MEM_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_idx),
    .wdata_i ({flags_q, frame_q, key_q}),
    .re_i    (ram_re),
    .raddr_i (issue_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  lkt_rank #(
    .ENTRIES (ENTRIES)
  ) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd_gated),
    .rd_idx_i   (pidx_q),
    .rd_valid_o (ent_valid),
    .rd_rank_o  (ent_rank)
  );

  lkt_scan #(
    .ENTRIES     (ENTRIES),
    .KEY_WIDTH   (KEY_WIDTH),
    .FRAME_WIDTH (FRAME_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .proc_i      (pvld_q),
    .idx_i       (pidx_q),
    .cmd_i       (cmd_q),
    .key_i       (key_q),
    .frame_i     (frame_q),
    .ent_valid_i (ent_valid),
    .ent_rank_i  (ent_rank),
    .ent_key_i   (ram_rdata[KEY_WIDTH-1:0]),
    .ent_frame_i (ram_rdata[KEY_WIDTH +: FRAME_WIDTH]),
    .ent_flags_i (ram_rdata[KEY_WIDTH + FRAME_WIDTH +: lkt_pkg::FLAGS_W]),
    .stat_o      (scan_stat),
    .hit_idx_o   (hit_idx),
    .hit_rank_o  (hit_rank),
    .hit_key_o   (hit_key),
    .hit_frame_o (hit_frame),
    .hit_flags_o (hit_flags),
    .free_idx_o  (free_idx)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

endmodule

### src/lkt_checker.sv
// ----------------------------------------------------------------------------
// lkt_checker: port-level checks of the LRU key table
// Watches the request and result channels and the result status.
// ----------------------------------------------------------------------------
`include "lru_key_table_top_defines.svh"

module lkt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [lkt_pkg::TDATA_W-1:0]   m_axis_tdata,
  input logic [lkt_pkg::STATUS_W-1:0]  m_axis_tuser
);

  `LKT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready high right after an accepted request")

  `LKT_ASSERT_SAME(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == lkt_pkg::STAT_MISS || m_axis_tuser == lkt_pkg::STAT_FULL), m_axis_tdata == '0, "miss or full result carries nonzero data")

  `LKT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind lru_key_table_top lkt_checker u_lkt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
